/* hw/rtl/mbb_pkg.sv */
package mbb_pkg;

    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int VALUE_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int MAX_DIM     = 4096;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNCERTAINTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGH_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGH_TOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGH_RIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROUGH_BOTTOM = 3'd7;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

    // edge flag positions
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } t_box;

    // frame size and search bands, derived from the registers
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] ls;
        logic [DIM_W-1:0]   le;
        logic [COORD_W-1:0] ts;
        logic [DIM_W-1:0]   te;
        logic [COORD_W-1:0] rs;
        logic [DIM_W-1:0]   re;
        logic [COORD_W-1:0] bs;
        logic [DIM_W-1:0]   be;
        logic               full_frame;
        logic               bad_box;
    } t_limits;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [3:0]         hit;
        logic               last;
        logic               bad_box;
    } t_qent;

endpackage

/* hw/rtl/mbb_cfg.sv */
module mbb_cfg import mbb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_limits               o_limits,
    output t_box                  o_rough,
    output logic [VALUE_W-1:0]    o_background,
    output logic                  o_settle
);

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [VALUE_W-1:0] r_background;
    logic [COORD_W-1:0] r_unc;
    t_box               r_rough;
    t_limits            r_limits;
    t_limits            n_limits;
    logic               r_settle;
    logic [DIM_W-1:0]   w_clamp;
    logic [DIM_W-1:0]   h_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= RESET_WIDTH;
            r_height     <= RESET_HEIGHT;
            r_background <= '0;
            r_unc        <= '0;
            r_rough      <= '0;
            r_settle     <= 1'b1;
        end else begin
            r_settle <= i_wr;
            if (i_wr) begin
                case (i_index)
                    REG_FRAME_WIDTH:  r_width      <= i_data;
                    REG_FRAME_HEIGHT: r_height     <= i_data;
                    REG_BACKGROUND:   r_background <= i_data[VALUE_W-1:0];
                    REG_UNCERTAINTY:  r_unc        <= i_data[COORD_W-1:0];
                    REG_ROUGH_LEFT:   r_rough.left   <= i_data[COORD_W-1:0];
                    REG_ROUGH_TOP:    r_rough.top    <= i_data[COORD_W-1:0];
                    REG_ROUGH_RIGHT:  r_rough.right  <= i_data[COORD_W-1:0];
                    REG_ROUGH_BOTTOM: r_rough.bottom <= i_data[COORD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    function automatic logic [COORD_W-1:0] band_lo(input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] u);
        band_lo = (r > u) ? r - u : '0;
    endfunction

    function automatic logic [DIM_W-1:0] band_hi(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] u,
                                                 input logic [DIM_W-1:0]   dim);
        logic [DIM_W-1:0] e;
        e = {1'b0, r} + {1'b0, u} + DIM_W'(1);
        band_hi = (e < dim) ? e : dim;
    endfunction

    always_comb begin
        if (r_width == '0) begin
            w_clamp = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_DIM)) begin
            w_clamp = DIM_W'(MAX_DIM);
        end else begin
            w_clamp = r_width;
        end
        if (r_height == '0) begin
            h_clamp = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_DIM)) begin
            h_clamp = DIM_W'(MAX_DIM);
        end else begin
            h_clamp = r_height;
        end
        n_limits.width      = w_clamp;
        n_limits.height     = h_clamp;
        n_limits.ls         = band_lo(r_rough.left, r_unc);
        n_limits.le         = band_hi(r_rough.left, r_unc, w_clamp);
        n_limits.ts         = band_lo(r_rough.top, r_unc);
        n_limits.te         = band_hi(r_rough.top, r_unc, h_clamp);
        n_limits.rs         = band_lo(r_rough.right, r_unc);
        n_limits.re         = band_hi(r_rough.right, r_unc, w_clamp);
        n_limits.bs         = band_lo(r_rough.bottom, r_unc);
        n_limits.be         = band_hi(r_rough.bottom, r_unc, h_clamp);
        n_limits.full_frame = (r_unc == '0);
        n_limits.bad_box    = (r_unc != '0) && ((r_rough.left > r_rough.right) ||
                                                (r_rough.top > r_rough.bottom));
    end

    // limits are registered from the band arithmetic, input is held off meanwhile
    always_ff @(posedge i_clk) begin
        r_limits <= n_limits;
    end

    assign o_limits     = r_limits;
    assign o_rough      = r_rough;
    assign o_background = r_background;
    assign o_settle     = r_settle;

endmodule

/* hw/rtl/mbb_front.sv */
module mbb_front import mbb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [VALUE_W-1:0] i_mask_value,
    input  logic [VALUE_W-1:0] i_background,
    input  t_limits            i_limits,
    output t_qent              o_entry
);

    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;
    logic [DIM_W-1:0]   col_next;
    logic [DIM_W-1:0]   row_next;
    logic               row_end;
    logic               frame_end;
    logic               is_mask;
    logic               in_cols;
    logic               in_rows;
    logic [3:0]         band_hit;
    logic [DIM_W-1:0]   x_ext;
    logic [DIM_W-1:0]   y_ext;

    assign x_ext     = {1'b0, r_col};
    assign y_ext     = {1'b0, r_row};
    assign col_next  = x_ext + DIM_W'(1);
    assign row_next  = y_ext + DIM_W'(1);
    assign row_end   = !(col_next < i_limits.width);
    assign frame_end = row_end && !(row_next < i_limits.height);
    assign is_mask   = (i_mask_value != i_background);

    assign in_cols = (r_col >= i_limits.ls) && (x_ext < i_limits.re);
    assign in_rows = (r_row >= i_limits.ts) && (y_ext < i_limits.be);

    always_comb begin
        band_hit[EDGE_TOP]    = in_cols && (r_row >= i_limits.ts) && (y_ext < i_limits.te);
        band_hit[EDGE_BOTTOM] = in_cols && (r_row >= i_limits.bs) && (y_ext < i_limits.be);
        band_hit[EDGE_LEFT]   = in_rows && (r_col >= i_limits.ls) && (x_ext < i_limits.le);
        band_hit[EDGE_RIGHT]  = in_rows && (r_col >= i_limits.rs) && (x_ext < i_limits.re);
    end

    always_comb begin
        o_entry.x       = r_col;
        o_entry.y       = r_row;
        o_entry.hit     = i_limits.full_frame ? {4{is_mask}} : (band_hit & {4{is_mask}});
        o_entry.last    = frame_end;
        o_entry.bad_box = i_limits.bad_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (!row_end) begin
                r_col <= col_next[COORD_W-1:0];
            end else begin
                r_col <= '0;
                r_row <= frame_end ? '0 : row_next[COORD_W-1:0];
            end
        end
    end

endmodule

/* hw/rtl/mbb_queue.sv */
module mbb_queue import mbb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    input  logic  i_pop,
    output t_qent o_head,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qent              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");
`endif

endmodule

/* hw/rtl/mbb_back.sv */
module mbb_back import mbb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_have,
    input  t_qent              i_entry,
    input  t_box               i_rough,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output t_box               o_box,
    output logic [3:0]         o_found
);

    logic [COORD_W-1:0] r_lc;
    logic [COORD_W-1:0] r_lr;
    logic [COORD_W-1:0] r_gc;
    logic [COORD_W-1:0] r_gr;
    logic [3:0]         r_flags;
    logic [COORD_W-1:0] n_lc;
    logic [COORD_W-1:0] n_lr;
    logic [COORD_W-1:0] n_gc;
    logic [COORD_W-1:0] n_gr;
    logic [3:0]         n_flags;
    logic               r_out_valid;
    t_box               r_box;
    logic [3:0]         r_found;
    logic               out_free;

    assign out_free = !r_out_valid || !i_stall;
    // a frame's last item waits until the output register can take the box
    assign o_pop    = i_have && (!i_entry.last || out_free);

    always_comb begin
        n_lc = (i_entry.hit[EDGE_LEFT]   && (i_entry.x <  r_lc)) ? i_entry.x : r_lc;
        n_lr = (i_entry.hit[EDGE_TOP]    && (i_entry.y <  r_lr)) ? i_entry.y : r_lr;
        n_gc = (i_entry.hit[EDGE_RIGHT]  && (i_entry.x >= r_gc)) ? i_entry.x : r_gc;
        n_gr = (i_entry.hit[EDGE_BOTTOM] && (i_entry.y >= r_gr)) ? i_entry.y : r_gr;
        n_flags = r_flags | i_entry.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc        <= '1;
            r_lr        <= '1;
            r_gc        <= '0;
            r_gr        <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_entry.last) begin
                r_lc        <= '1;
                r_lr        <= '1;
                r_gc        <= '0;
                r_gr        <= '0;
                r_flags     <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_pop) begin
                    r_lc    <= n_lc;
                    r_lr    <= n_lr;
                    r_gc    <= n_gc;
                    r_gr    <= n_gr;
                    r_flags <= n_flags;
                end
                if (!i_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            if (i_entry.bad_box) begin
                r_box   <= i_rough;
                r_found <= '0;
            end else begin
                r_box.left   <= n_lc;
                r_box.top    <= n_lr;
                r_box.right  <= n_gc;
                r_box.bottom <= n_gr;
                r_found      <= n_flags;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_box   = r_box;
    assign o_found = r_found;

`ifndef ASSERT_OFF
    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |=> (r_flags == '0) && r_out_valid)
        else $error("accumulators not cleared after frame end");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(o_pop && i_entry.last))
        else $error("pending box overwritten");
`endif

endmodule

/* hw/rtl/mask_bounding_box.sv */
// channel   | valid         | flow control  | payload
// ----------+---------------+---------------+-----------------------------------
// pixel in  | i_valid       | o_stall       | i_mask_value
// box out   | o_valid       | i_stall       | o_box_*, o_*_found
// config    | i_cfg_valid   | o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one pixel per cycle while o_stall is low; pixels are classified against the
// search bands on entry and queued, the back end folds one queued pixel per
// cycle into the min/max registers and loads the box into the output register.
// synchronous active-low reset; input stalls after reset and after each register
// write while the band limits are recomputed. o_stall rises when the queue is
// full or the limits settle; the back end stops only on a frame's last pixel
// while an earlier box is still held in the output register.
module mask_bounding_box import mbb_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_W-1:0]    i_mask_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_W-1:0]    o_box_left,
    output logic [COORD_W-1:0]    o_box_top,
    output logic [COORD_W-1:0]    o_box_right,
    output logic [COORD_W-1:0]    o_box_bottom,
    output logic                  o_left_found,
    output logic                  o_top_found,
    output logic                  o_right_found,
    output logic                  o_bottom_found,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_limits            limits;
    t_box               rough;
    t_box               box;
    logic [VALUE_W-1:0] background;
    logic               settle;
    t_qent              in_entry;
    t_qent              head;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic               accept;
    logic [3:0]         found;

    assign o_stall     = q_full || settle;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = q_empty;

    mbb_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (i_cfg_valid && o_cfg_ready),
        .i_index      (i_cfg_index),
        .i_data       (i_cfg_data),
        .o_limits     (limits),
        .o_rough      (rough),
        .o_background (background),
        .o_settle     (settle)
    );

    mbb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mask_value (i_mask_value),
        .i_background (background),
        .i_limits     (limits),
        .o_entry      (in_entry)
    );

    mbb_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (in_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mbb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_have  (!q_empty),
        .i_entry (head),
        .i_rough (rough),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_box   (box),
        .o_found (found)
    );

    assign o_box_left     = box.left;
    assign o_box_top      = box.top;
    assign o_box_right    = box.right;
    assign o_box_bottom   = box.bottom;
    assign o_left_found   = found[EDGE_LEFT];
    assign o_top_found    = found[EDGE_TOP];
    assign o_right_found  = found[EDGE_RIGHT];
    assign o_bottom_found = found[EDGE_BOTTOM];

endmodule

/* test/mask_bounding_box_tb.sv */
module mask_bounding_box_tb;
    import mbb_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_PCT     = 31;

    typedef struct packed {
        t_box       box;
        logic [3:0] found;
    } t_box_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [VALUE_W-1:0]    i_mask_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [COORD_W-1:0]    o_box_left;
    logic [COORD_W-1:0]    o_box_top;
    logic [COORD_W-1:0]    o_box_right;
    logic [COORD_W-1:0]    o_box_bottom;
    logic                  o_left_found;
    logic                  o_top_found;
    logic                  o_right_found;
    logic                  o_bottom_found;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    mask_bounding_box dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mask_value   (i_mask_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_box_left     (o_box_left),
        .o_box_top      (o_box_top),
        .o_box_right    (o_box_right),
        .o_box_bottom   (o_box_bottom),
        .o_left_found   (o_left_found),
        .o_top_found    (o_top_found),
        .o_right_found  (o_right_found),
        .o_bottom_found (o_bottom_found),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the registers
    int unsigned cfg_width = 32'(RESET_WIDTH);
    int unsigned cfg_height = 32'(RESET_HEIGHT);
    int unsigned cfg_background = 0;
    int unsigned cfg_uncert = 0;
    int unsigned cfg_rough_left = 0;
    int unsigned cfg_rough_top = 0;
    int unsigned cfg_rough_right = 0;
    int unsigned cfg_rough_bottom = 0;

    // running frame state of the predictor
    int unsigned col_pos, row_pos;
    int unsigned least_col, least_row, greatest_col, greatest_row;
    logic [3:0]  found_flags;

    t_box_report box_q[$];
    t_box_report want_box;
    int          fail_count = 0;
    int unsigned pixels_sent = 0;
    bit          steady = 1'b0;

    function automatic void clear_frame_state();
        col_pos      = 0;
        row_pos      = 0;
        least_col    = 32'hFFFF_FFFF;
        least_row    = 32'hFFFF_FFFF;
        greatest_col = 0;
        greatest_row = 0;
        found_flags  = '0;
    endfunction

    function automatic int unsigned clamp_dim(int unsigned d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return d;
    endfunction

    function automatic int unsigned band_lo(int unsigned r);
        return (r > cfg_uncert) ? r - cfg_uncert : 0;
    endfunction

    function automatic int unsigned band_hi(int unsigned r, int unsigned dim);
        int unsigned e;
        e = r + cfg_uncert + 1;
        return (e < dim) ? e : dim;
    endfunction

    // folds one pixel into the frame state, queues a box at the frame's end
    function automatic void fold_pixel(logic [VALUE_W-1:0] v);
        int unsigned w, h, x, y;
        int unsigned ls, le, ts, te, rs, re, bs, be;
        bit          in_cols, in_rows;
        t_box_report rep;
        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        x = col_pos;
        y = row_pos;
        if (32'(v) != cfg_background) begin
            if (cfg_uncert == 0) begin
                if (x < least_col) least_col = x;
                if (y < least_row) least_row = y;
                if (x > greatest_col) greatest_col = x;
                if (y > greatest_row) greatest_row = y;
                found_flags = '1;
            end else begin
                ls = band_lo(cfg_rough_left);
                le = band_hi(cfg_rough_left, w);
                ts = band_lo(cfg_rough_top);
                te = band_hi(cfg_rough_top, h);
                rs = band_lo(cfg_rough_right);
                re = band_hi(cfg_rough_right, w);
                bs = band_lo(cfg_rough_bottom);
                be = band_hi(cfg_rough_bottom, h);
                in_cols = (x >= ls) && (x < re);
                in_rows = (y >= ts) && (y < be);
                if (in_cols && y >= ts && y < te) begin
                    if (y < least_row) least_row = y;
                    found_flags[EDGE_TOP] = 1'b1;
                end
                if (in_cols && y >= bs && y < be) begin
                    if (y >= greatest_row) greatest_row = y;
                    found_flags[EDGE_BOTTOM] = 1'b1;
                end
                if (in_rows && x >= ls && x < le) begin
                    if (x < least_col) least_col = x;
                    found_flags[EDGE_LEFT] = 1'b1;
                end
                if (in_rows && x >= rs && x < re) begin
                    if (x >= greatest_col) greatest_col = x;
                    found_flags[EDGE_RIGHT] = 1'b1;
                end
            end
        end
        if (x + 1 < w) begin
            col_pos = x + 1;
            return;
        end
        col_pos = 0;
        if (y + 1 < h) begin
            row_pos = y + 1;
            return;
        end
        if (cfg_uncert != 0 &&
            (cfg_rough_left > cfg_rough_right || cfg_rough_top > cfg_rough_bottom)) begin
            // invalid rough box goes out as it came in
            rep.box.left   = cfg_rough_left[COORD_W-1:0];
            rep.box.top    = cfg_rough_top[COORD_W-1:0];
            rep.box.right  = cfg_rough_right[COORD_W-1:0];
            rep.box.bottom = cfg_rough_bottom[COORD_W-1:0];
            rep.found      = '0;
        end else begin
            rep.box.left   = least_col[COORD_W-1:0];
            rep.box.top    = least_row[COORD_W-1:0];
            rep.box.right  = greatest_col[COORD_W-1:0];
            rep.box.bottom = greatest_row[COORD_W-1:0];
            rep.found      = found_flags;
        end
        box_q.push_back(rep);
        clear_frame_state();
    endfunction

    task automatic send_pixel(input logic [VALUE_W-1:0] v);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mask_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        fold_pixel(v);
        pixels_sent++;
    endtask

    // stop sending, let every box come out and the queue run dry
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (box_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width        = 32'(data);
            REG_FRAME_HEIGHT: cfg_height       = 32'(data);
            REG_BACKGROUND:   cfg_background   = 32'(data[VALUE_W-1:0]);
            REG_UNCERTAINTY:  cfg_uncert       = 32'(data[COORD_W-1:0]);
            REG_ROUGH_LEFT:   cfg_rough_left   = 32'(data[COORD_W-1:0]);
            REG_ROUGH_TOP:    cfg_rough_top    = 32'(data[COORD_W-1:0]);
            REG_ROUGH_RIGHT:  cfg_rough_right  = 32'(data[COORD_W-1:0]);
            REG_ROUGH_BOTTOM: cfg_rough_bottom = 32'(data[COORD_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned w, h, bg, u, l, t, r, b);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_BACKGROUND, CFG_DATA_W'(bg));
        write_reg(REG_UNCERTAINTY, CFG_DATA_W'(u));
        write_reg(REG_ROUGH_LEFT, CFG_DATA_W'(l));
        write_reg(REG_ROUGH_TOP, CFG_DATA_W'(t));
        write_reg(REG_ROUGH_RIGHT, CFG_DATA_W'(r));
        write_reg(REG_ROUGH_BOTTOM, CFG_DATA_W'(b));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_whole_frame();
        configure(2, 2, 8'h00, 0, 0, 0, 0, 0);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'h00);
        // frame of background only: nothing found
        configure(2, 2, 8'hFF, 0, 0, 0, 0, 0);
        repeat (4) send_pixel(8'hFF);
    endtask

    task automatic test_refine_bands();
        configure(3, 2, 8'h80, 1, 2, 0, 2, 1);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'h80);
        send_pixel(8'h80);
        send_pixel(8'h80);
        send_pixel(8'h00);
    endtask

    task automatic test_invalid_rough_box();
        configure(1, 1, 8'h00, 1, 5, 0, 3, 0);
        send_pixel(8'h11);
        configure(1, 1, 8'h00, 4095, 0, 4095, 4095, 0);
        send_pixel(8'h22);
    endtask

    task automatic test_size_clamp();
        // zero width and height act as one
        configure(0, 0, 8'h00, 0, 0, 0, 0, 0);
        send_pixel(8'h01);
        send_pixel(8'h00);
    endtask

    task automatic test_empty_band();
        // left band starts past the frame, so the column window is empty too
        configure(2, 2, 8'h00, 1, 4000, 0, 4001, 1);
        repeat (4) send_pixel(8'hC3);
    endtask

    task automatic test_shrink_mid_frame();
        configure(4, 2, 8'h00, 0, 0, 0, 0, 0);
        repeat (5) send_pixel(8'hF0);
        wait_idle();
        // column 1 is now past the last column: row and frame end here
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        i_cfg_valid <= 1'b0;
        send_pixel(8'h0F);
    endtask

    task automatic test_random_frames();
        int unsigned w, h, u, l, t, r, b, bg, dens, frames, start, tmp;
        logic [VALUE_W-1:0] px;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_ITEMS) begin
            steady = (pixels_sent - start) < 300;
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            h = $urandom_range(1, 8);
            bg = $urandom_range(0, 255);
            case ($urandom_range(9))
                0, 1, 2: u = 0;
                3:       u = 4095;
                4:       u = $urandom_range(0, 4095);
                default: u = $urandom_range(1, 3);
            endcase
            l = $urandom_range(0, w - 1);
            r = $urandom_range(0, w - 1);
            t = $urandom_range(0, h - 1);
            b = $urandom_range(0, h - 1);
            if (l > r) begin tmp = l; l = r; r = tmp; end
            if (t > b) begin tmp = t; t = b; b = tmp; end
            case ($urandom_range(9))
                0: begin
                    l = $urandom_range(0, 4095);
                    t = $urandom_range(0, 4095);
                    r = $urandom_range(0, 4095);
                    b = $urandom_range(0, 4095);
                end
                1: begin
                    tmp = l; l = r; r = tmp;
                    tmp = t; t = b; b = tmp;
                end
                2: begin
                    // junk above the register width is dropped
                    l = l + 4096;
                    t = t + 4096;
                    u = u + 4096;
                    bg = bg + 256 * $urandom_range(1, 31);
                end
                default: ;
            endcase
            configure(w, h, bg, u, l, t, r, b);
            frames = $urandom_range(1, 4);
            repeat (frames) begin
                dens = $urandom_range(0, 100);
                repeat (w * h) begin
                    px = ($urandom_range(99) < dens) ? VALUE_W'($urandom) : VALUE_W'(bg);
                    send_pixel(px);
                end
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_largest_frames();
        logic [VALUE_W-1:0] bg8;
        bg8 = 8'h5A;
        // width above the limit acts as 4096, zero height as one row;
        // a width write partway along cuts the row short
        configure(8191, 0, bg8, 0, 0, 0, 0, 0);
        for (int i = 0; i < 200; i++)
            send_pixel((i < 2 || i == 199 || $urandom_range(63) == 0) ? ~bg8 : bg8);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(200));
        i_cfg_valid <= 1'b0;
        send_pixel(~bg8);
        bg8 = 8'hA5;
        // height above the limit acts as 4096, cut short the same way
        configure(1, 8191, bg8, 1, 0, 197, 0, 199);
        for (int i = 0; i < 200; i++)
            send_pixel((i < 2 || i == 199 || $urandom_range(63) == 0) ? ~bg8 : bg8);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(200));
        i_cfg_valid <= 1'b0;
        send_pixel(~bg8);
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] want_v,
                               input logic [COORD_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (box_q.size() == 0) begin
                $error("unexpected box: left %0d top %0d right %0d bottom %0d",
                       o_box_left, o_box_top, o_box_right, o_box_bottom);
                fail_count++;
            end else begin
                want_box = box_q.pop_front();
                check_field("box_left", want_box.box.left, o_box_left);
                check_field("box_top", want_box.box.top, o_box_top);
                check_field("box_right", want_box.box.right, o_box_right);
                check_field("box_bottom", want_box.box.bottom, o_box_bottom);
                check_field("left_found", COORD_W'(want_box.found[EDGE_LEFT]),
                            COORD_W'(o_left_found));
                check_field("top_found", COORD_W'(want_box.found[EDGE_TOP]),
                            COORD_W'(o_top_found));
                check_field("right_found", COORD_W'(want_box.found[EDGE_RIGHT]),
                            COORD_W'(o_right_found));
                check_field("bottom_found", COORD_W'(want_box.found[EDGE_BOTTOM]),
                            COORD_W'(o_bottom_found));
            end
        end
    end

    initial begin
        clear_frame_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_whole_frame();
        test_refine_bands();
        test_invalid_rough_box();
        test_size_clamp();
        test_empty_band();
        test_shrink_mid_frame();
        test_random_frames();
        test_largest_frames();
        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mbb_pkg.sv
hw/rtl/mbb_cfg.sv
hw/rtl/mbb_front.sv
hw/rtl/mbb_queue.sv
hw/rtl/mbb_back.sv
hw/rtl/mask_bounding_box.sv
test/mask_bounding_box_tb.sv
